>>> src/gbdq_pkg.sv
package gbdq_pkg;

	// Register map of the configuration port
	localparam int unsigned REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ORIGIN_X      = 3'd0,
		REG_ORIGIN_Y      = 3'd1,
		REG_LIMIT_X       = 3'd2,
		REG_LIMIT_Y       = 3'd3,
		REG_INV_CELL_SIZE = 3'd4,
		REG_GRID_WIDTH    = 3'd5,
		REG_GRID_HEIGHT   = 3'd6
	} reg_idx_t;

	// Item opcodes
	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	localparam int unsigned DIM_W = 9;

	// 1.0 in Q0.16, one bit wider than a fraction
	localparam logic [16:0] FRAC_ONE = 17'h1_0000;

	// Reset values of the configuration registers
	localparam logic [31:0]      INV_CELL_RESET = 32'h0001_0000;
	localparam logic [DIM_W-1:0] DIM_RESET      = 9'd1;

	typedef struct packed {
		logic [31:0]      origin_x;
		logic [31:0]      origin_y;
		logic [31:0]      limit_x;
		logic [31:0]      limit_y;
		logic [31:0]      inv_cell_size;
		logic [DIM_W-1:0] grid_width;
		logic [DIM_W-1:0] grid_height;
	} cfg_t;

	// Item as it travels through the mapping stages
	typedef struct packed {
		op_t         op;
		logic        outside;
		logic [15:0] cell_index;
		logic [31:0] cell_value;
		logic [15:0] fx;
		logic [15:0] fy;
	} item_t;

	// One row beat from the fetch stage to the blend pipeline
	typedef struct packed {
		logic        last;
		logic        outside;
		logic [15:0] fx;
		logic [15:0] fy;
	} beat_t;

endpackage

>>> src/gbdq_if.sv
// Input item channel
interface gbdq_item_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic [15:0]        cell_index;
	logic [31:0]        cell_value;
	logic signed [31:0] query_x;
	logic signed [31:0] query_y;

	modport source (output valid, op, cell_index, cell_value, query_x, query_y, input ready);
	modport sink (input valid, op, cell_index, cell_value, query_x, query_y, output ready);
endinterface

// Result channel
interface gbdq_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] distance;
	logic        outside;

	modport source (output valid, distance, outside, input ready);
	modport sink (input valid, distance, outside, output ready);
endinterface

// Configuration write channel
interface gbdq_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [gbdq_pkg::REG_IDX_W-1:0] index;
	logic [31:0]                   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/gbdq_map.sv
module gbdq_map #(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256,
	localparam int unsigned IW = $clog2(MAX_WIDTH),
	localparam int unsigned AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	gbdq_item_if.sink            item,
	input  gbdq_pkg::cfg_t       cfg,
	output logic                 out_valid,
	input  logic                 out_ready,
	output gbdq_pkg::item_t      out_item,
	output logic [AW-1:0]        out_base0,
	output logic [AW-1:0]        out_base1,
	output logic [IW-1:0]        out_i0,
	output logic [IW-1:0]        out_i1
);

	localparam int unsigned JW = $clog2(MAX_HEIGHT);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned PW = JW + WW;

	// Grid size in use: zero counts as one, saturate at the store size
	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;
	logic [WW-1:0] last_xw;
	logic [HW-1:0] last_yw;
	logic [IW-1:0] last_x;
	logic [JW-1:0] last_y;

	always_comb begin
		if (cfg.grid_width == '0) begin
			eff_w = WW'(1);
		end else if (32'(cfg.grid_width) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(cfg.grid_width);
		end
		if (cfg.grid_height == '0) begin
			eff_h = HW'(1);
		end else if (32'(cfg.grid_height) > MAX_HEIGHT) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(cfg.grid_height);
		end
	end

	assign last_xw = eff_w - WW'(1);
	assign last_yw = eff_h - HW'(1);
	assign last_x  = last_xw[IW-1:0];
	assign last_y  = last_yw[JW-1:0];

	// Stage valids and ready chain
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4       = !v_s4 || out_ready;
	assign rdy3       = !v_s3 || rdy4;
	assign rdy2       = !v_s2 || rdy3;
	assign rdy1       = !v_s1 || rdy2;
	assign item.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= item.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Stage 1: box test and offset from origin
	logic        outside_c;
	logic [31:0] dx_c, dy_c;

	assign outside_c = ($signed(item.query_x) < $signed(cfg.origin_x)) ||
	                   ($signed(item.query_x) > $signed(cfg.limit_x))  ||
	                   ($signed(item.query_y) < $signed(cfg.origin_y)) ||
	                   ($signed(item.query_y) > $signed(cfg.limit_y));
	assign dx_c = item.query_x - cfg.origin_x;
	assign dy_c = item.query_y - cfg.origin_y;

	gbdq_pkg::item_t it_s1, it_s2, it_s3, it_s4;
	logic [31:0]     dx_s1, dy_s1;

	// Stage 2: scale to grid units (Q32.32, low 16 bits dropped)
	logic [63:0] gx_c, gy_c;
	logic [47:0] gx_s2, gy_s2;

	assign gx_c = dx_s1 * cfg.inv_cell_size;
	assign gy_c = dy_s1 * cfg.inv_cell_size;

	// Stage 3: clamp neighbour cells to the grid in use
	logic [31:0]   ipx, ipy;
	logic [32:0]   ipx1, ipy1;
	logic [IW-1:0] i0_c, i1_c, i0_s3, i1_s3, i0_s4, i1_s4;
	logic [JW-1:0] j0_c, j1_c, j0_s3, j1_s3;

	assign ipx  = gx_s2[47:16];
	assign ipy  = gy_s2[47:16];
	assign ipx1 = {1'b0, ipx} + 33'd1;
	assign ipy1 = {1'b0, ipy} + 33'd1;
	assign i0_c = (ipx > 32'(last_x)) ? last_x : ipx[IW-1:0];
	assign i1_c = (ipx1 > 33'(last_x)) ? last_x : ipx1[IW-1:0];
	assign j0_c = (ipy > 32'(last_y)) ? last_y : ipy[JW-1:0];
	assign j1_c = (ipy1 > 33'(last_y)) ? last_y : ipy1[JW-1:0];

	// Stage 4: row base addresses
	logic [PW-1:0] row0_c, row1_c;
	logic [AW-1:0] base0_s4, base1_s4;

	assign row0_c = PW'(j0_s3) * PW'(eff_w);
	assign row1_c = PW'(j1_s3) * PW'(eff_w);

	always_ff @(posedge clk) begin
		if (rdy1) begin
			it_s1 <= '{op:         gbdq_pkg::op_t'(item.op),
			           outside:    outside_c,
			           cell_index: item.cell_index,
			           cell_value: item.cell_value,
			           fx:         16'd0,
			           fy:         16'd0};
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
		end
		if (rdy2) begin
			it_s2 <= it_s1;
			gx_s2 <= gx_c[63:16];
			gy_s2 <= gy_c[63:16];
		end
		if (rdy3) begin
			it_s3 <= '{op:         it_s2.op,
			           outside:    it_s2.outside,
			           cell_index: it_s2.cell_index,
			           cell_value: it_s2.cell_value,
			           fx:         gx_s2[15:0],
			           fy:         gy_s2[15:0]};
			i0_s3 <= i0_c;
			i1_s3 <= i1_c;
			j0_s3 <= j0_c;
			j1_s3 <= j1_c;
		end
		if (rdy4) begin
			it_s4    <= it_s3;
			i0_s4    <= i0_s3;
			i1_s4    <= i1_s3;
			base0_s4 <= row0_c[AW-1:0];
			base1_s4 <= row1_c[AW-1:0];
		end
	end

	assign out_valid = v_s4;
	assign out_item  = it_s4;
	assign out_base0 = base0_s4;
	assign out_base1 = base1_s4;
	assign out_i0    = i0_s4;
	assign out_i1    = i1_s4;

endmodule

>>> src/gbdq_fetch.sv
module gbdq_fetch #(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256,
	localparam int unsigned IW = $clog2(MAX_WIDTH),
	localparam int unsigned AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  gbdq_pkg::item_t      in_item,
	input  logic [AW-1:0]        in_base0,
	input  logic [AW-1:0]        in_base1,
	input  logic [IW-1:0]        in_i0,
	input  logic [IW-1:0]        in_i1,
	output logic                 out_valid,
	input  logic                 out_ready,
	output gbdq_pkg::beat_t      out_beat,
	output logic [31:0]          out_a,
	output logic [31:0]          out_b
);

	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;

	// Grid store: one write port, two registered read ports.
	// Loads and reads issue from this one stage in item order, so a read
	// never overlaps a write and needs no forwarding.
	logic [31:0] grid_mem [DEPTH];

	logic          phase_q;
	logic          beat_v_q;
	gbdq_pkg::beat_t beat_q;
	logic [31:0]   rd_a_q, rd_b_q;

	logic          is_load, is_short, last_beat, beat_ok;
	logic          rd_en, wr_en;
	logic [AW-1:0] base, addr_a, addr_b, waddr;
	logic [31:0]   widx;

	assign is_load   = (in_item.op == gbdq_pkg::OP_LOAD);
	assign is_short  = is_load || in_item.outside;
	assign last_beat = in_item.outside || phase_q;
	assign beat_ok   = !beat_v_q || out_ready;

	// Loads leave at once; a query leaves with its last row beat
	assign in_ready = is_load || (beat_ok && last_beat);

	// Row j0 first, then row j1
	assign base   = phase_q ? in_base1 : in_base0;
	assign addr_a = base + AW'(in_i0);
	assign addr_b = base + AW'(in_i1);
	assign rd_en  = in_valid && !is_short && beat_ok;

	assign widx  = 32'(in_item.cell_index);
	assign waddr = widx[AW-1:0];
	assign wr_en = in_valid && is_load && (widx < DEPTH);

	always_ff @(posedge clk) begin
		if (wr_en) grid_mem[waddr] <= in_item.cell_value;
		if (rd_en) begin
			rd_a_q <= grid_mem[addr_a];
			rd_b_q <= grid_mem[addr_b];
		end
	end

	// Row phase and beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			beat_v_q <= 1'b0;
		end else begin
			if (rd_en) phase_q <= !phase_q;
			if (beat_ok) beat_v_q <= in_valid && !is_load;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_ok) begin
			beat_q <= '{last:    last_beat,
			            outside: in_item.outside,
			            fx:      in_item.fx,
			            fy:      in_item.fy};
		end
	end

	assign out_valid = beat_v_q;
	assign out_beat  = beat_q;
	assign out_a     = rd_a_q;
	assign out_b     = rd_b_q;

endmodule

>>> src/gbdq_blend.sv
module gbdq_blend (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  gbdq_pkg::beat_t in_beat,
	input  logic [31:0]     in_a,
	input  logic [31:0]     in_b,
	gbdq_result_if.source   result
);

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;
	logic out_free, take3;
	logic res_valid_q;

	gbdq_pkg::beat_t beat_s1, beat_s2, beat_s3;

	// Row 0 beats fold into the accumulator; the last beat needs the output slot
	assign out_free = !res_valid_q || result.ready;
	assign take3    = !beat_s3.last || out_free;
	assign rdy3     = !v_s3 || take3;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (out_free) res_valid_q <= v_s3 && beat_s3.last;
		end
	end

	// Stage 1: horizontal weights, Q16.32 partial products
	logic [16:0] wx0_c, wy_c;
	logic [47:0] p0_c, p1_c, p0_s1, p1_s1;

	assign wx0_c = gbdq_pkg::FRAC_ONE - {1'b0, in_beat.fx};
	assign p0_c  = in_a * wx0_c;
	assign p1_c  = in_b * in_beat.fx;

	// Stage 2: row blend
	logic [47:0] r_s2;

	// Stage 3: vertical weight for this row (Q16.48)
	logic [63:0] m_c, m_s3;

	assign wy_c = beat_s2.last ? {1'b0, beat_s2.fy}
	                           : (gbdq_pkg::FRAC_ONE - {1'b0, beat_s2.fy});
	assign m_c  = r_s2 * wy_c;

	// Output: sum both rows and round to Q16.16
	logic [63:0] acc_q, total_c;
	logic [31:0] dist_q;
	logic        outside_q;

	assign total_c = acc_q + m_s3 + 64'h0000_0000_8000_0000;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			beat_s1 <= in_beat;
			p0_s1   <= p0_c;
			p1_s1   <= p1_c;
		end
		if (rdy2) begin
			beat_s2 <= beat_s1;
			r_s2    <= p0_s1 + p1_s1;
		end
		if (rdy3) begin
			beat_s3 <= beat_s2;
			m_s3    <= m_c;
		end
		if (v_s3 && !beat_s3.last) acc_q <= m_s3;
		if (out_free && v_s3 && beat_s3.last) begin
			dist_q    <= beat_s3.outside ? 32'd0 : total_c[63:32];
			outside_q <= beat_s3.outside;
		end
	end

	assign result.valid    = res_valid_q;
	assign result.distance = dist_q;
	assign result.outside  = outside_q;

endmodule

>>> src/grid_bilinear_distance_query.sv
// Throughput: one load or outside query per cycle while the result channel does not stall; an inside
// query reads its two rows in turn, limited by the two read ports of the grid memory (four cells per
// query, two per cycle).
// Reset: clears all valid and phase state and sets the registers to their defaults; grid
// contents are undefined until loaded and get no clearing pass.
module grid_bilinear_distance_query #(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	gbdq_cfg_if.sink      cfg,
	gbdq_item_if.sink     item,
	gbdq_result_if.source result
);

	localparam int unsigned IW = $clog2(MAX_WIDTH);
	localparam int unsigned AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

	// Configuration registers, always ready
	gbdq_pkg::cfg_t cfg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x      <= 32'd0;
			cfg_q.origin_y      <= 32'd0;
			cfg_q.limit_x       <= 32'd0;
			cfg_q.limit_y       <= 32'd0;
			cfg_q.inv_cell_size <= gbdq_pkg::INV_CELL_RESET;
			cfg_q.grid_width    <= gbdq_pkg::DIM_RESET;
			cfg_q.grid_height   <= gbdq_pkg::DIM_RESET;
		end else if (cfg.valid) begin
			case (gbdq_pkg::reg_idx_t'(cfg.index))
				gbdq_pkg::REG_ORIGIN_X:      cfg_q.origin_x      <= cfg.data;
				gbdq_pkg::REG_ORIGIN_Y:      cfg_q.origin_y      <= cfg.data;
				gbdq_pkg::REG_LIMIT_X:       cfg_q.limit_x       <= cfg.data;
				gbdq_pkg::REG_LIMIT_Y:       cfg_q.limit_y       <= cfg.data;
				gbdq_pkg::REG_INV_CELL_SIZE: cfg_q.inv_cell_size <= cfg.data;
				gbdq_pkg::REG_GRID_WIDTH: begin
					cfg_q.grid_width <= cfg.data[gbdq_pkg::DIM_W-1:0];
				end
				gbdq_pkg::REG_GRID_HEIGHT: begin
					cfg_q.grid_height <= cfg.data[gbdq_pkg::DIM_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// Map stages to fetch
	logic            map_valid, map_ready;
	gbdq_pkg::item_t map_item;
	logic [AW-1:0]   map_base0, map_base1;
	logic [IW-1:0]   map_i0, map_i1;

	// Fetch to blend
	logic            beat_valid, beat_ready;
	gbdq_pkg::beat_t beat;
	logic [31:0]     cell_a, cell_b;

	gbdq_map #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg       (cfg_q),
		.out_valid (map_valid),
		.out_ready (map_ready),
		.out_item  (map_item),
		.out_base0 (map_base0),
		.out_base1 (map_base1),
		.out_i0    (map_i0),
		.out_i1    (map_i1)
	);

	gbdq_fetch #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_fetch (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (map_valid),
		.in_ready  (map_ready),
		.in_item   (map_item),
		.in_base0  (map_base0),
		.in_base1  (map_base1),
		.in_i0     (map_i0),
		.in_i1     (map_i1),
		.out_valid (beat_valid),
		.out_ready (beat_ready),
		.out_beat  (beat),
		.out_a     (cell_a),
		.out_b     (cell_b)
	);

	gbdq_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (beat_valid),
		.in_ready (beat_ready),
		.in_beat  (beat),
		.in_a     (cell_a),
		.in_b     (cell_b),
		.result   (result)
	);

endmodule

>>> verif/grid_bilinear_distance_query_test.sv
module grid_bilinear_distance_query_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned GRID_MAX_W     = 256;
	localparam int unsigned GRID_MAX_H     = 256;
	localparam int unsigned RAND_PER_PHASE = 35;
	localparam int unsigned SETTLE_CYCLES  = 24;
	localparam int unsigned TIMEOUT_CYCLES = 600000;
	localparam longint      Q_MIN          = -64'sd2147483648;
	localparam longint      Q_MAX          = 64'sd2147483647;

	// Index with no register behind it
	localparam logic [gbdq_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		gbdq_pkg::op_t      op;
		logic [15:0]        cell_index;
		logic [31:0]        cell_value;
		logic signed [31:0] query_x;
		logic signed [31:0] query_y;
	} grid_item_t;

	typedef struct {
		logic [31:0] distance;
		logic        outside;
	} lookup_t;

	logic clk;
	logic arst_n;

	gbdq_cfg_if    cfg_ch();
	gbdq_item_if   item_ch();
	gbdq_result_if result_ch();

	grid_bilinear_distance_query #(
		.MAX_WIDTH  (GRID_MAX_W),
		.MAX_HEIGHT (GRID_MAX_H)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	// Shadow of the registers and of the sample store
	gbdq_pkg::cfg_t grid_cfg;
	logic [31:0]    grid_mem [0:65535];

	grid_item_t  pending_items[$];
	lookup_t     expected_lookups[$];
	grid_item_t  cur_item;

	int          send_idle_pct;
	int          recv_stall_pct;
	int          mismatch_count;
	int unsigned cycle_count;

	// Clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > TIMEOUT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	function automatic int unsigned clamp_dim(input logic [gbdq_pkg::DIM_W-1:0] v,
			input int unsigned maxv);
		if (v == '0)
			return 1;
		return (v > maxv) ? maxv : int'(v);
	endfunction

	// One axis into grid space: clamped neighbor cells and Q0.16 fraction
	function automatic void map_axis(input logic signed [31:0] p, input logic signed [31:0] org,
			input int unsigned cells, output int unsigned lo, output int unsigned hi,
			output logic [15:0] frac);
		logic [63:0] d, g, ip, last;
		d    = 64'(longint'(p) - longint'(org));
		g    = d * {32'd0, grid_cfg.inv_cell_size};
		ip   = g >> 32;
		last = 64'(cells) - 64'd1;
		lo   = (ip > last) ? 32'(last) : 32'(ip);
		hi   = (ip + 64'd1 > last) ? 32'(last) : 32'(ip + 64'd1);
		frac = g[31:16];
	endfunction

	// Bilinear blend of the four cells around a point
	function automatic lookup_t blend_lookup(input logic signed [31:0] qx,
			input logic signed [31:0] qy);
		lookup_t     res;
		int unsigned w, h, i0, i1, j0, j1;
		logic [15:0] fx, fy;
		logic [63:0] c00, c10, c01, c11, fx64, fy64, wx, wy, r0, r1, total;
		if (qx < $signed(grid_cfg.origin_x) || qx > $signed(grid_cfg.limit_x) ||
				qy < $signed(grid_cfg.origin_y) || qy > $signed(grid_cfg.limit_y)) begin
			res.distance = '0;
			res.outside  = 1'b1;
			return res;
		end
		w = clamp_dim(grid_cfg.grid_width, GRID_MAX_W);
		h = clamp_dim(grid_cfg.grid_height, GRID_MAX_H);
		map_axis(qx, $signed(grid_cfg.origin_x), w, i0, i1, fx);
		map_axis(qy, $signed(grid_cfg.origin_y), h, j0, j1, fy);
		c00   = {32'd0, grid_mem[16'(j0 * w + i0)]};
		c10   = {32'd0, grid_mem[16'(j0 * w + i1)]};
		c01   = {32'd0, grid_mem[16'(j1 * w + i0)]};
		c11   = {32'd0, grid_mem[16'(j1 * w + i1)]};
		fx64  = {48'd0, fx};
		fy64  = {48'd0, fy};
		wx    = 64'(gbdq_pkg::FRAC_ONE) - fx64;
		wy    = 64'(gbdq_pkg::FRAC_ONE) - fy64;
		r0    = c00 * wx + c10 * fx64;
		r1    = c01 * wx + c11 * fx64;
		total = r0 * wy + r1 * fy64;
		res.distance = 32'((total + 64'h8000_0000) >> 32);
		res.outside  = 1'b0;
		return res;
	endfunction

	// Apply one accepted transaction to the shadow state
	function automatic void track_item(input grid_item_t it);
		if (it.op == gbdq_pkg::OP_LOAD)
			grid_mem[it.cell_index] = it.cell_value;
		else
			expected_lookups.insert(expected_lookups.size(),
				blend_lookup(it.query_x, it.query_y));
	endfunction

	// Item driver
	always @(posedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				track_item(cur_item);
			if (!item_ch.valid || item_ch.ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_item = pending_items.pop_front();
					item_ch.valid      <= 1'b1;
					item_ch.op         <= cur_item.op;
					item_ch.cell_index <= cur_item.cell_index;
					item_ch.cell_value <= cur_item.cell_value;
					item_ch.query_x    <= cur_item.query_x;
					item_ch.query_y    <= cur_item.query_y;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stalls
	always @(posedge clk) begin : result_mon
		lookup_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_lookups.size() == 0) begin
					report_mismatch($sformatf("result with no query pending: distance %h outside %b",
						result_ch.distance, result_ch.outside));
				end else begin
					want = expected_lookups.pop_front();
					if (result_ch.distance !== want.distance)
						report_mismatch($sformatf("distance %h, expected %h",
							result_ch.distance, want.distance));
					if (result_ch.outside !== want.outside)
						report_mismatch($sformatf("outside %b, expected %b",
							result_ch.outside, want.outside));
				end
			end
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// One register write transaction
	task automatic write_reg(input logic [gbdq_pkg::REG_IDX_W-1:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			gbdq_pkg::REG_ORIGIN_X:      grid_cfg.origin_x      = data;
			gbdq_pkg::REG_ORIGIN_Y:      grid_cfg.origin_y      = data;
			gbdq_pkg::REG_LIMIT_X:       grid_cfg.limit_x       = data;
			gbdq_pkg::REG_LIMIT_Y:       grid_cfg.limit_y       = data;
			gbdq_pkg::REG_INV_CELL_SIZE: grid_cfg.inv_cell_size = data;
			gbdq_pkg::REG_GRID_WIDTH:    grid_cfg.grid_width    = data[gbdq_pkg::DIM_W-1:0];
			gbdq_pkg::REG_GRID_HEIGHT:   grid_cfg.grid_height   = data[gbdq_pkg::DIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [31:0] ox, input logic [31:0] oy,
			input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] inv,
			input logic [gbdq_pkg::DIM_W-1:0] w, input logic [gbdq_pkg::DIM_W-1:0] h);
		write_reg(gbdq_pkg::REG_ORIGIN_X, ox);
		write_reg(gbdq_pkg::REG_ORIGIN_Y, oy);
		write_reg(gbdq_pkg::REG_LIMIT_X, lx);
		write_reg(gbdq_pkg::REG_LIMIT_Y, ly);
		write_reg(gbdq_pkg::REG_INV_CELL_SIZE, inv);
		// upper data bits are don't care for the dimensions
		write_reg(gbdq_pkg::REG_GRID_WIDTH, {23'($urandom), w});
		write_reg(gbdq_pkg::REG_GRID_HEIGHT, {23'($urandom), h});
	endtask

	task automatic set_idle(input int mode);
		case (mode)
			1: begin send_idle_pct = 58; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 58; end
			3: begin send_idle_pct = 17; recv_stall_pct = 17; end
			default: begin send_idle_pct = 0; recv_stall_pct = 0; end
		endcase
	endtask

	task automatic push_load(input logic [15:0] idx, input logic [31:0] val);
		grid_item_t it;
		it.op         = gbdq_pkg::OP_LOAD;
		it.cell_index = idx;
		it.cell_value = val;
		it.query_x    = $urandom;
		it.query_y    = $urandom;
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic push_query(input logic signed [31:0] qx, input logic signed [31:0] qy);
		grid_item_t it;
		it.op         = gbdq_pkg::OP_QUERY;
		it.cell_index = $urandom;
		it.cell_value = $urandom;
		it.query_x    = qx;
		it.query_y    = qy;
		pending_items.insert(pending_items.size(), it);
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Every cell in use gets written before any query can read it
	task automatic fill_grid();
		int unsigned cells;
		cells = clamp_dim(grid_cfg.grid_width, GRID_MAX_W) *
			clamp_dim(grid_cfg.grid_height, GRID_MAX_H);
		for (int unsigned k = 0; k < cells; k++)
			push_load(16'(k), pick_sample());
	endtask

	// Coordinate within [lo, hi], bounds favored; any value for an empty range
	function automatic logic signed [31:0] pick_inside(input logic signed [31:0] lo,
			input logic signed [31:0] hi);
		logic [63:0] span, off;
		if (hi < lo)
			return $urandom;
		span = 64'(longint'(hi) - longint'(lo));
		case ($urandom_range(7))
			0: off = 64'd0;
			1: off = span;
			default: off = {$urandom, $urandom} % (span + 64'd1);
		endcase
		return 32'(longint'(lo) + longint'(off));
	endfunction

	// Coordinate just or far past a bound; any value when no room is left past it
	function automatic logic signed [31:0] step_outside(input logic signed [31:0] bound,
			input logic downward);
		longint room, off;
		room = downward ? longint'(bound) - Q_MIN : Q_MAX - longint'(bound);
		if (room == 0)
			return $urandom;
		off = $urandom_range(1) ? 1 : longint'({32'd0, $urandom} % room) + 1;
		return downward ? 32'(longint'(bound) - off) : 32'(longint'(bound) + off);
	endfunction

	task automatic push_random(input int unsigned n);
		logic signed [31:0] qx, qy;
		int unsigned        cells;
		cells = clamp_dim(grid_cfg.grid_width, GRID_MAX_W) *
			clamp_dim(grid_cfg.grid_height, GRID_MAX_H);
		for (int unsigned k = 0; k < n; k++) begin
			if ($urandom_range(99) < 25) begin
				// loads land in the grid in use or anywhere in the store
				if ($urandom_range(1))
					push_load(16'($urandom_range(cells - 1)), pick_sample());
				else
					push_load(16'($urandom), pick_sample());
			end else begin
				qx = pick_inside($signed(grid_cfg.origin_x), $signed(grid_cfg.limit_x));
				qy = pick_inside($signed(grid_cfg.origin_y), $signed(grid_cfg.limit_y));
				if ($urandom_range(99) < 25) begin
					case ($urandom_range(4))
						0: begin qx = $urandom; qy = $urandom; end
						1: qx = step_outside($signed(grid_cfg.origin_x), 1'b1);
						2: qx = step_outside($signed(grid_cfg.limit_x), 1'b0);
						3: qy = step_outside($signed(grid_cfg.origin_y), 1'b1);
						default: qy = step_outside($signed(grid_cfg.limit_y), 1'b0);
					endcase
				end
				push_query(qx, qy);
			end
		end
	endtask

	// Wait until every transaction is through and the pipeline has emptied;
	// sampled mid-cycle so the driver's updates at the edge have settled
	task automatic drain();
		do @(negedge clk);
		while (pending_items.size() != 0 || item_ch.valid || expected_lookups.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int mode);
		logic [31:0]                ox, oy, inv;
		logic [gbdq_pkg::DIM_W-1:0] w, h;
		ox  = 32'($signed($urandom) >>> 1);
		oy  = 32'($signed($urandom) >>> 1);
		w   = gbdq_pkg::DIM_W'($urandom_range(1, 16));
		h   = gbdq_pkg::DIM_W'($urandom_range(1, 16));
		inv = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0000_4000, 32'h0004_0000);
		set_idle(mode);
		set_config(ox, oy, ox + $urandom_range(1, 32'h0040_0000),
			oy + $urandom_range(1, 32'h0040_0000), inv, w, h);
		fill_grid();
		push_random(RAND_PER_PHASE);
		drain();
	endtask

	task automatic fixed_phase(input int mode, input logic [31:0] ox, input logic [31:0] oy,
			input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] inv,
			input logic [gbdq_pkg::DIM_W-1:0] w, input logic [gbdq_pkg::DIM_W-1:0] h);
		set_idle(mode);
		set_config(ox, oy, lx, ly, inv, w, h);
		fill_grid();
		push_random(RAND_PER_PHASE);
		drain();
	endtask

	// Stimulus sequence
	initial begin
		arst_n             = 1'b0;
		item_ch.valid      = 1'b0;
		item_ch.op         = gbdq_pkg::OP_LOAD;
		item_ch.cell_index = '0;
		item_ch.cell_value = '0;
		item_ch.query_x    = '0;
		item_ch.query_y    = '0;
		result_ch.ready    = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = gbdq_pkg::REG_ORIGIN_X;
		cfg_ch.data        = '0;
		mismatch_count     = 0;
		cycle_count        = 0;
		grid_cfg.origin_x      = '0;
		grid_cfg.origin_y      = '0;
		grid_cfg.limit_x       = '0;
		grid_cfg.limit_y       = '0;
		grid_cfg.inv_cell_size = gbdq_pkg::INV_CELL_RESET;
		grid_cfg.grid_width    = gbdq_pkg::DIM_RESET;
		grid_cfg.grid_height   = gbdq_pkg::DIM_RESET;
		set_idle(0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Register defaults: a single cell and a box of one point
		push_load(16'd0, 32'hFFFF_FFFF);
		push_query(32'sd0, 32'sd0);
		push_query(32'sd1, 32'sd0);
		push_query(32'sd0, -32'sd1);
		drain();

		// Directed: 4x3 grid, unit cells, bounds and just past them
		set_config(32'hFFFE_0000, 32'h0001_8000, 32'h0002_0000, 32'h0004_8000,
			32'h0001_0000, 9'd4, 9'd3);
		fill_grid();
		push_load(16'd0, 32'h0000_0000);
		push_load(16'd1, 32'hFFFF_FFFF);
		push_query(32'shFFFE_0000, 32'sh0001_8000);
		push_query(32'sh0002_0000, 32'sh0004_8000);
		push_query(32'sh0002_0000, 32'sh0001_8000);
		push_query(32'shFFFE_0000, 32'sh0004_8000);
		push_query(32'sh0000_8000, 32'sh0002_4000);
		push_query(32'shFFFD_FFFF, 32'sh0001_8000);
		push_query(32'sh0002_0001, 32'sh0004_8000);
		push_query(32'shFFFE_0000, 32'sh0001_7FFF);
		push_query(32'sh0002_0000, 32'sh0004_8001);
		push_query(32'sh7FFF_FFFF, 32'sh8000_0000);
		drain();

		// Random phases over a range of settings and idling patterns
		fixed_phase(1, 32'hFFF7_C000, 32'hFFFD_0000, 32'hFFFA_C000, 32'hFFFF_8000,
			32'h0002_0000, 9'd6, 9'd5);
		// widest grid, box starting at the lowest coordinate
		fixed_phase(2, 32'h8000_0000, 32'h0000_0000, 32'h8100_0000, 32'h0002_0000,
			32'h0001_0000, 9'd256, 9'd2);
		// tallest grid, box reaching past the last column
		fixed_phase(3, 32'h0000_0000, 32'h000A_0000, 32'h0003_0000, 32'h010A_0000,
			32'h0001_0000, 9'd2, 9'd256);
		fixed_phase(0, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000,
			32'h0000_8000, 9'd1, 9'd1);
		// zero width reads as one, oversize height saturates
		fixed_phase(1, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0100_0000,
			32'h0001_0000, 9'd0, 9'h1FF);
		// zero reciprocal maps everything to cell zero
		fixed_phase(2, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000,
			32'h0000_0000, 9'd5, 9'd5);
		// full coordinate range, largest reciprocal: most points past the grid
		fixed_phase(3, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 9'd7, 9'd9);
		// empty box: origin above limit on both axes
		fixed_phase(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h0001_0000, 9'd3, 9'd3);
		random_phase(1);
		// a write to the unmapped index must change nothing
		write_reg(REG_UNUSED, $urandom);
		set_idle(2);
		push_random(RAND_PER_PHASE);
		drain();
		random_phase(3);

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
